@@ design/cab_pkg.sv @@
// Shared types and operation codes for the 8/16-bit BCD-capable CPU ALU.
// No dependencies; used by cab_alu, cab_regs and cpu_alu_8_16_bit_bcd.
`default_nettype none

package cab_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned DataW = 16;

  localparam logic [OpW-1:0] OP_ADC = 5'd0;
  localparam logic [OpW-1:0] OP_AND = 5'd1;
  localparam logic [OpW-1:0] OP_ASL = 5'd2;
  localparam logic [OpW-1:0] OP_BIT = 5'd3;
  localparam logic [OpW-1:0] OP_CMP = 5'd4;
  localparam logic [OpW-1:0] OP_CPX = 5'd5;
  localparam logic [OpW-1:0] OP_CPY = 5'd6;
  localparam logic [OpW-1:0] OP_DEC = 5'd7;
  localparam logic [OpW-1:0] OP_EOR = 5'd8;
  localparam logic [OpW-1:0] OP_INC = 5'd9;
  localparam logic [OpW-1:0] OP_LDA = 5'd10;
  localparam logic [OpW-1:0] OP_LDX = 5'd11;
  localparam logic [OpW-1:0] OP_LDY = 5'd12;
  localparam logic [OpW-1:0] OP_LSR = 5'd13;
  localparam logic [OpW-1:0] OP_ORA = 5'd14;
  localparam logic [OpW-1:0] OP_ROL = 5'd15;
  localparam logic [OpW-1:0] OP_ROR = 5'd16;
  localparam logic [OpW-1:0] OP_SBC = 5'd17;
  localparam logic [OpW-1:0] OP_TRB = 5'd18;
  localparam logic [OpW-1:0] OP_TSB = 5'd19;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             wide;
    logic             decimal;
    logic             carry_in;
    logic [DataW-1:0] operand_data;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             carry_out;
    logic             zero_out;
    logic             negative_out;
    logic             overflow_out;
    logic             overflow_valid;
  } out_item_t;

  // Register file write request produced by the ALU for one word.
  typedef struct packed {
    logic             acc_we;
    logic             x_we;
    logic             y_we;
    logic             wide;
    logic [DataW-1:0] value;
  } reg_wr_t;

endpackage

`default_nettype wire

@@ design/cab_regs.sv @@
// Accumulator and X/Y index registers with 8-bit writes that keep the high byte.
// Depends on cab_pkg for the write request type.
`default_nettype none

module cab_regs (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire cab_pkg::reg_wr_t        wr,
  output logic [cab_pkg::DataW-1:0]    acc,
  output logic [cab_pkg::DataW-1:0]    idx_x,
  output logic [cab_pkg::DataW-1:0]    idx_y
);

  logic [cab_pkg::DataW-1:0] acc_next;
  logic [cab_pkg::DataW-1:0] x_next;
  logic [cab_pkg::DataW-1:0] y_next;

  always_comb begin
    acc_next = wr.wide ? wr.value : {acc[15:8], wr.value[7:0]};
    x_next   = wr.wide ? wr.value : {idx_x[15:8], wr.value[7:0]};
    y_next   = wr.wide ? wr.value : {idx_y[15:8], wr.value[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      idx_x <= '0;
      idx_y <= '0;
    end else if (wr_en) begin
      if (wr.acc_we) acc <= acc_next;
      if (wr.x_we) idx_x <= x_next;
      if (wr.y_we) idx_y <= y_next;
    end
  end

endmodule

`default_nettype wire

@@ design/cab_alu.sv @@
// Combinational datapath: binary/BCD add-subtract, logic, shifts, compares, loads, inc/dec, bit ops.
// Depends on cab_pkg for item types and operation codes.
`default_nettype none

module cab_alu (
  input  wire cab_pkg::in_item_t         item,
  input  wire logic [cab_pkg::DataW-1:0] acc,
  input  wire logic [cab_pkg::DataW-1:0] idx_x,
  input  wire logic [cab_pkg::DataW-1:0] idx_y,
  output cab_pkg::out_item_t             res,
  output cab_pkg::reg_wr_t               wr
);

  logic [15:0] full;
  logic [15:0] top;
  logic [15:0] d;
  logic [15:0] a;
  logic        sub;
  logic [15:0] db;
  logic [16:0] bin;
  logic [4:0]  dsum;
  logic [5:0]  adj;
  logic        dc;
  logic [15:0] bcd_r;
  logic [3:0]  dig_s3;
  logic [3:0]  dig_c;
  logic [15:0] as_r;
  logic        as_c;
  logic        as_rtop;
  logic        atop;
  logic        dtop;
  logic        as_v;
  logic [15:0] cmp_reg;
  logic [16:0] diff;
  logic [15:0] r;
  logic        c;
  logic        z;
  logic        n;
  logic        v;
  logic        vv;
  logic        zset;
  logic        ntop;
  logic        known;
  logic        z_and;

  always_comb begin
    full = item.wide ? 16'hFFFF : 16'h00FF;
    top  = item.wide ? 16'h8000 : 16'h0080;
    d    = item.operand_data & full;
    a    = acc & full;
    sub  = (item.op == cab_pkg::OP_SBC);
    db   = sub ? (~d & full) : d;
    bin  = {1'b0, a} + {1'b0, db} + 17'(item.carry_in);

    // Decimal chain: each digit adds, then adjusts by six as the mode requires.
    // Invalid digits run through the same adjust as valid ones.
    dc    = item.carry_in;
    bcd_r = '0;
    dig_s3 = '0;
    dig_c  = '0;
    adj    = '0;
    dsum   = '0;
    for (int i = 0; i < 4; i++) begin
      dsum = {1'b0, a[4*i +: 4]} + {1'b0, db[4*i +: 4]} + 5'(dc);
      dig_s3[i] = dsum[3];
      if (!sub) begin
        adj = (dsum >= 5'd10) ? (6'(dsum) + 6'h06) : 6'(dsum);
        dc  = adj[5] | adj[4];
        bcd_r[4*i +: 4] = adj[3:0];
      end else begin
        dc = dsum[4];
        bcd_r[4*i +: 4] = dc ? dsum[3:0] : (dsum[3:0] - 4'h6);
      end
      dig_c[i] = dc;
    end

    if (item.decimal) begin
      as_r    = bcd_r & full;
      as_c    = item.wide ? dig_c[3] : dig_c[1];
      as_rtop = item.wide ? dig_s3[3] : dig_s3[1];
    end else begin
      as_r    = bin[15:0] & full;
      as_c    = item.wide ? bin[16] : bin[8];
      as_rtop = item.wide ? bin[15] : bin[7];
    end
    // Overflow uses the top bit before the final decimal adjust.
    atop = item.wide ? a[15] : a[7];
    dtop = item.wide ? db[15] : db[7];
    as_v = ~(atop ^ dtop) & (atop ^ as_rtop);

    case (item.op)
      cab_pkg::OP_CMP: cmp_reg = acc & full;
      cab_pkg::OP_CPX: cmp_reg = idx_x & full;
      default:         cmp_reg = idx_y & full;
    endcase
    diff  = {1'b0, cmp_reg} - {1'b0, d};
    z_and = ((d & a) == 16'h0000);

    r     = '0;
    c     = item.carry_in;
    v     = 1'b0;
    vv    = 1'b0;
    zset  = 1'b0;
    z     = 1'b0;
    ntop  = 1'b1;
    known = 1'b1;
    wr    = '{acc_we: 1'b0, x_we: 1'b0, y_we: 1'b0, wide: item.wide, value: '0};

    case (item.op)
      cab_pkg::OP_ADC, cab_pkg::OP_SBC: begin
        r = as_r; c = as_c; v = as_v; vv = 1'b1;
        wr.acc_we = 1'b1;
      end
      cab_pkg::OP_AND: begin r = a & d; wr.acc_we = 1'b1; end
      cab_pkg::OP_EOR: begin r = a ^ d; wr.acc_we = 1'b1; end
      cab_pkg::OP_ORA: begin r = a | d; wr.acc_we = 1'b1; end
      cab_pkg::OP_ASL: begin c = |(d & top); r = (d << 1) & full; end
      cab_pkg::OP_LSR: begin c = d[0]; r = d >> 1; end
      cab_pkg::OP_ROL: begin c = |(d & top); r = ((d << 1) | 16'(item.carry_in)) & full; end
      cab_pkg::OP_ROR: begin c = d[0]; r = (item.carry_in ? top : 16'h0000) | (d >> 1); end
      cab_pkg::OP_BIT: begin
        r = d; vv = 1'b1;
        v = |(d & (top >> 1));
        z = z_and; zset = 1'b1;
      end
      cab_pkg::OP_CMP, cab_pkg::OP_CPX, cab_pkg::OP_CPY: begin
        c = ~diff[16];
        r = diff[15:0] & full;
      end
      cab_pkg::OP_DEC: r = (d - 16'h0001) & full;
      cab_pkg::OP_INC: r = (d + 16'h0001) & full;
      cab_pkg::OP_LDA: begin r = d; wr.acc_we = 1'b1; end
      cab_pkg::OP_LDX: begin r = d; wr.x_we = 1'b1; end
      cab_pkg::OP_LDY: begin r = d; wr.y_we = 1'b1; end
      cab_pkg::OP_TRB, cab_pkg::OP_TSB: begin
        z = z_and; zset = 1'b1; ntop = 1'b0;
        r = (item.op == cab_pkg::OP_TRB) ? (d & ~a & full) : (d | a);
      end
      default: known = 1'b0;
    endcase

    wr.value = r;
    if (!zset) z = (r == 16'h0000);
    if (item.op == cab_pkg::OP_BIT) n = |(d & top);
    else n = ntop & |(r & top);

    if (known) begin
      res = '{result_value: r, carry_out: c, zero_out: z, negative_out: n,
              overflow_out: vv & v, overflow_valid: vv};
    end else begin
      res = '{result_value: '0, carry_out: item.carry_in, zero_out: 1'b0,
              negative_out: 1'b0, overflow_out: 1'b0, overflow_valid: 1'b0};
    end
  end

endmodule

`default_nettype wire

@@ design/cpu_alu_8_16_bit_bcd.sv @@
// Top level of the 8/16-bit BCD-capable CPU ALU: input register, datapath, result register.
// Depends on cab_pkg, cab_alu and cab_regs.
//
//   channel | signals                     | payload type
//   input   | in_valid, in_ready, in_item | cab_pkg::in_item_t
//   output  | out_valid, out_ready, out_item | cab_pkg::out_item_t
//
// A word passes the input register, then the result register, where its result becomes valid;
// one word is accepted per cycle when the output drains.
// The register file updates when a word moves from the input to the result register,
// so the next word sees the new accumulator and index values.
// Synchronous reset clears the register file and both valid flags; a stalled output
// holds its word while the input register can still take one more.
`default_nettype none

module cpu_alu_8_16_bit_bcd (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cab_pkg::in_item_t    in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cab_pkg::out_item_t        out_item
);

  logic                      s1_valid;
  cab_pkg::in_item_t         s1_item;
  logic                      advance;
  cab_pkg::out_item_t        alu_res;
  cab_pkg::reg_wr_t          alu_wr;
  logic [cab_pkg::DataW-1:0] acc;
  logic [cab_pkg::DataW-1:0] idx_x;
  logic [cab_pkg::DataW-1:0] idx_y;

  assign advance  = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | advance;

  cab_alu u_alu (
    .item  (s1_item),
    .acc   (acc),
    .idx_x (idx_x),
    .idx_y (idx_y),
    .res   (alu_res),
    .wr    (alu_wr)
  );

  cab_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (advance),
    .wr    (alu_wr),
    .acc   (acc),
    .idx_x (idx_x),
    .idx_y (idx_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= alu_res;
    end
  end

endmodule

`default_nettype wire
